[rtl/core/sld_pkg.sv]
`default_nettype none

package sld_pkg;

  // Frame header bytes 'A', 'T', 'S'
  localparam logic [7:0] HDR0_BYTE = 8'h41;
  localparam logic [7:0] HDR1_BYTE = 8'h54;
  localparam logic [7:0] HDR2_BYTE = 8'h53;

  // Receive phase: header hunt, length, payload, checksum
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_LEN  = 3'd3,
    PH_PAY  = 3'd4,
    PH_CSUM = 3'd5
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  // One result request
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/sync_length_checksum_deframer.sv]
// Frame deframer for a received byte stream. Bytes enter on the in_ channel;
// the block hunts for the header 'A' 'T' 'S', takes a length byte L, then
// max(L-1,1) payload bytes, each sent out as a payload request with its
// index, and a checksum byte that yields a good or bad status request
// (8-bit wrapping sum of the first L bytes from the length byte on).
// Header and length bytes give no output. One byte is taken every clock
// while in_stall is low: the frame state updates per accepted byte, and a
// two-entry output buffer (output register plus skid entry) holds results,
// so in_stall rises only after out_stall has held back two pending
// requests. Results are registered in the output buffer.
`default_nettype none

module sync_length_checksum_deframer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic [7:0] out_frame_length
);
  import sld_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  // Frame state machine
  sld_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_rx_byte (in_rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register with skid entry
  sld_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind   = out_res.kind;
  assign out_payload_byte  = out_res.data;
  assign out_payload_index = out_res.index;
  assign out_frame_length  = out_res.length;

endmodule

`default_nettype wire

[rtl/core/sld_fsm.sv]
`default_nettype none

module sld_fsm (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_accept,
  input  wire  [7:0]       in_rx_byte,
  output logic             res_valid,
  output sld_pkg::result_t res
);
  import sld_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [8:0] count_inc;
  logic [8:0] need;

  assign count_inc = {1'b0, count_r} + 9'd1;
  // Payload bytes to take: max(L-1, 1)
  assign need = (length_r >= 8'd2) ? ({1'b0, length_r} - 9'd1) : 9'd1;

  // Next state and result for the byte at the input
  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res.kind   = KIND_PAYLOAD;
    res.data   = in_rx_byte;
    res.index  = 8'd0;
    res.length = length_r;
    case (phase_r)
      PH_HDR0: begin
        if (in_rx_byte == HDR0_BYTE) begin
          phase_nxt = PH_HDR1;
        end else begin
          phase_nxt = PH_HDR0;
          count_nxt = 8'd0;
          sum_nxt   = 8'd0;
        end
      end
      PH_HDR1: begin
        if (in_rx_byte == HDR1_BYTE) begin
          phase_nxt = PH_HDR2;
        end else begin
          phase_nxt = PH_HDR0;
          count_nxt = 8'd0;
          sum_nxt   = 8'd0;
        end
      end
      PH_HDR2: begin
        if (in_rx_byte == HDR2_BYTE) begin
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HDR0;
          count_nxt = 8'd0;
          sum_nxt   = 8'd0;
        end
      end
      PH_LEN: begin
        // checksum starts with the length byte itself
        length_nxt = in_rx_byte;
        count_nxt  = 8'd0;
        sum_nxt    = in_rx_byte;
        phase_nxt  = PH_PAY;
      end
      PH_PAY: begin
        // only the first L-1 payload bytes are summed
        if (count_inc < {1'b0, length_r}) begin
          sum_nxt = sum_r + in_rx_byte;
        end
        res_valid = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.index = count_r;
        count_nxt = count_inc[7:0];
        if (count_inc >= need) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        res_valid = 1'b1;
        res.kind  = (in_rx_byte == sum_r) ? KIND_GOOD : KIND_BAD;
        phase_nxt = PH_HDR0;
        count_nxt = 8'd0;
        sum_nxt   = 8'd0;
      end
      default: begin
        phase_nxt = PH_HDR0;
        count_nxt = 8'd0;
        sum_nxt   = 8'd0;
      end
    endcase
  end

  // State registers, updated per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      length_r <= 8'd0;
      count_r  <= 8'd0;
      sum_r    <= 8'd0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
    end
  end

  // Payload counter stays below the byte budget of the frame
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY && length_r >= 8'd2) |-> ({1'b0, count_r} < need))
    else $error("payload count overran frame length");

  // Checksum byte ends the frame with a clean hunt state
  a_csum_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == PH_CSUM) |=>
      (phase_r == PH_HDR0 && count_r == 8'd0 && sum_r == 8'd0))
    else $error("frame end did not return to hunt");

  // Length byte is captured and payload phase entered
  a_len_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == PH_LEN) |=>
      (phase_r == PH_PAY && length_r == $past(in_rx_byte) && sum_r == $past(in_rx_byte)))
    else $error("length byte not captured");

endmodule

`default_nettype wire

[rtl/core/sld_obuf.sv]
`default_nettype none

module sld_obuf (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  sld_pkg::result_t push_res,
  output logic             full,
  output logic             out_valid,
  input  wire              out_stall,
  output sld_pkg::result_t out_res
);
  import sld_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_r;
  result_t skid_r;
  logic    out_fire;
  logic    out_free;

  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_fire;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_free) begin
        out_r <= push_res;
      end else begin
        skid_r <= push_res;
      end
    end
  end

  // Skid entry only holds data behind a waiting output
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // A push while the skid is full would lose a request
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("request pushed into full buffer");

endmodule

`default_nettype wire
